/* hdl/a64sed_pkg.sv */
// ----------------------------------------------------------------------------
// a64sed_pkg
// Shared types and encoding constants for the AArch64 store emulation decoder.
// ----------------------------------------------------------------------------
package a64sed_pkg;

  // Stream widths: payload fields packed low to high, padded to whole bytes
  localparam int unsigned IN_W  = 416;
  localparam int unsigned OUT_W = 400;

  // Encoding classes, instruction bits 29:27
  localparam logic [2:0] CLASS_PAIR   = 3'b101;
  localparam logic [2:0] CLASS_SINGLE = 3'b111;

  // Pair addressing, bits 24:23
  localparam logic [1:0] PAIR_NOALLOC = 2'd0;
  localparam logic [1:0] PAIR_POST    = 2'd1;
  localparam logic [1:0] PAIR_OFFSET  = 2'd2;
  localparam logic [1:0] PAIR_PRE     = 2'd3;

  // Single-register index mode, bits 11:10
  localparam logic [1:0] IDX_POST = 2'd1;
  localparam logic [1:0] IDX_PRE  = 2'd3;

  // Load/store opc values of interest
  localparam logic [1:0] OPC_STR   = 2'd0;
  localparam logic [1:0] OPC_STRQ  = 2'd2;
  localparam logic [1:0] OPC_RSVD  = 2'd3;
  localparam logic [1:0] OPC_PAIRX = 2'd2;

  localparam logic [4:0] REG_ZR = 5'd31;

  // Element size as log2 of bytes
  localparam logic [2:0] SC_B = 3'd0;
  localparam logic [2:0] SC_H = 3'd1;
  localparam logic [2:0] SC_W = 3'd2;
  localparam logic [2:0] SC_D = 3'd3;
  localparam logic [2:0] SC_Q = 3'd4;

  typedef struct packed {
    logic [63:0] second_hi;
    logic [63:0] second_lo;
    logic [63:0] first_hi;
    logic [63:0] first_lo;
    logic [63:0] pc;
    logic [63:0] fault_address;
    logic [31:0] instruction;
  } item_t;

  typedef struct packed {
    logic [63:0] next_pc;
    logic [63:0] writeback_value;
    logic [4:0]  writeback_reg;
    logic        writeback_enable;
    logic [63:0] data_word3;
    logic [63:0] data_word2;
    logic [63:0] data_word1;
    logic [63:0] data_word0;
    logic [5:0]  store_bytes;
    logic        handled;
  } result_t;

endpackage

/* hdl/a64sed_decode.sv */
// ----------------------------------------------------------------------------
// a64sed_decode
// Combinational decode of one store instruction into byte image and writeback.
// ----------------------------------------------------------------------------
module a64sed_decode (
  input  a64sed_pkg::item_t   item,
  output a64sed_pkg::result_t res
);

  logic [31:0] insn;
  logic [4:0]  rt, rn, rt2;
  logic        v;
  logic        is_pair, is_single;
  logic [63:0] a_lo, a_hi, b_lo, b_hi;
  logic [2:0]  scale_p, scale_s;
  logic        pair_ok, single_ok;
  logic [63:0] imm7_sx, imm9_sx;
  logic        wb;
  logic [63:0] wbval;

  assign insn      = item.instruction;
  assign rt        = insn[4:0];
  assign rn        = insn[9:5];
  assign rt2       = insn[14:10];
  assign v         = insn[26];
  assign is_pair   = (insn[29:27] == a64sed_pkg::CLASS_PAIR) && !insn[22];
  assign is_single = (insn[29:27] == a64sed_pkg::CLASS_SINGLE);
  assign imm7_sx   = {{57{insn[21]}}, insn[21:15]};
  assign imm9_sx   = {{55{insn[20]}}, insn[20:12]};

  // Integer operands: register 31 is XZR, upper halves unused
  assign a_lo = (!v && rt == a64sed_pkg::REG_ZR) ? 64'd0 : item.first_lo;
  assign b_lo = (!v && rt2 == a64sed_pkg::REG_ZR) ? 64'd0 : item.second_lo;
  assign a_hi = v ? item.first_hi : 64'd0;
  assign b_hi = v ? item.second_hi : 64'd0;

  assign pair_ok = is_pair && !(v && insn[31:30] == a64sed_pkg::OPC_RSVD);
  assign scale_p = v ? (3'd2 + {1'b0, insn[31:30]})
                     : ((insn[31:30] == a64sed_pkg::OPC_PAIRX) ? a64sed_pkg::SC_D
                                                              : a64sed_pkg::SC_W);

  assign single_ok = is_single &&
    (v ? (insn[23:22] == a64sed_pkg::OPC_STR || insn[23:22] == a64sed_pkg::OPC_STRQ)
       : (insn[23:22] == a64sed_pkg::OPC_STR));
  assign scale_s = (v && insn[23:22] == a64sed_pkg::OPC_STRQ) ? a64sed_pkg::SC_Q
                                                               : {1'b0, insn[31:30]};

  always_comb begin
    res                  = '0;
    res.next_pc          = item.pc;
    wb                   = 1'b0;
    wbval                = 64'd0;
    if (pair_ok) begin
      res.handled     = 1'b1;
      res.store_bytes = 6'd2 << scale_p;
      unique case (scale_p)
        a64sed_pkg::SC_W: begin
          res.data_word0 = {b_lo[31:0], a_lo[31:0]};
        end
        a64sed_pkg::SC_D: begin
          res.data_word0 = a_lo;
          res.data_word1 = b_lo;
        end
        a64sed_pkg::SC_Q: begin
          res.data_word0 = a_lo;
          res.data_word1 = a_hi;
          res.data_word2 = b_lo;
          res.data_word3 = b_hi;
        end
        default: begin
          res.data_word0 = 64'd0;
        end
      endcase
      unique case (insn[24:23])
        a64sed_pkg::PAIR_PRE: begin
          wb    = 1'b1;
          wbval = item.fault_address;
        end
        a64sed_pkg::PAIR_POST: begin
          wb    = 1'b1;
          wbval = item.fault_address + (imm7_sx << scale_p);
        end
        default: begin
          wb = 1'b0;
        end
      endcase
    end else if (single_ok) begin
      res.handled     = 1'b1;
      res.store_bytes = 6'd1 << scale_s;
      unique case (scale_s)
        a64sed_pkg::SC_B: res.data_word0 = {56'd0, a_lo[7:0]};
        a64sed_pkg::SC_H: res.data_word0 = {48'd0, a_lo[15:0]};
        a64sed_pkg::SC_W: res.data_word0 = {32'd0, a_lo[31:0]};
        a64sed_pkg::SC_D: res.data_word0 = a_lo;
        default: begin
          res.data_word0 = a_lo;
          res.data_word1 = a_hi;
        end
      endcase
      // Only the unscaled/indexed register-immediate group has writeback
      if (insn[25:24] == 2'b00 && !insn[21]) begin
        unique case (insn[11:10])
          a64sed_pkg::IDX_PRE: begin
            wb    = 1'b1;
            wbval = item.fault_address;
          end
          a64sed_pkg::IDX_POST: begin
            wb    = 1'b1;
            wbval = item.fault_address + imm9_sx;
          end
          default: begin
            wb = 1'b0;
          end
        endcase
      end
    end
    if (res.handled) begin
      res.next_pc = item.pc + 64'd4;
    end
    res.writeback_enable = wb;
    res.writeback_reg    = wb ? rn : 5'd0;
    res.writeback_value  = wbval;
  end

endmodule

/* hdl/arm64_store_emulation_decode.sv */
// ----------------------------------------------------------------------------
// arm64_store_emulation_decode
// Decodes one faulting AArch64 store into its byte image and base writeback.
// ----------------------------------------------------------------------------
// Usage
//   Slave side (s_*) takes one transaction per faulting store: the instruction
//   word, fault address, PC and the values of the registers named by Rt and
//   Rt2 (low and high halves). Master side (m_*) returns one transaction per
//   input: the store byte image (up to 32 bytes in four words), its length,
//   the base register writeback for pre/post-index forms and the next PC.
//   m_tuser carries 'handled'; loads and undecoded words come back with
//   handled low, zero data and next_pc equal to pc.
// Timing
//   Two register stages: an input register, then the decode logic, then a
//   result register; each transaction passes both before its output
//   handshake. Throughput is one transaction per cycle while m_tready is
//   high; each stage refills in the same cycle it drains, so s_tready stays
//   high while the output keeps moving.
// Reset and back-pressure
//   rst (synchronous, active high) empties both stages. If m_tready is held
//   low the result stays put, the input stage fills behind it, and then
//   s_tready drops until the master side drains again.
// ----------------------------------------------------------------------------
module arm64_store_emulation_decode (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // instruction, fault_address, pc, first_lo, first_hi, second_lo, second_hi
  input  logic [a64sed_pkg::IN_W-1:0]  s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // store_bytes, data_word0..3, writeback_enable, writeback_reg,
  // writeback_value, next_pc, 4 zero pad bits
  output logic [a64sed_pkg::OUT_W-1:0] m_tdata,
  // handled
  output logic [0:0]                   m_tuser
);

  a64sed_pkg::item_t   in_reg;
  logic                in_valid;
  logic                in_ready;
  a64sed_pkg::result_t dec_res;
  a64sed_pkg::result_t out_reg;
  logic                out_valid;
  logic                out_ready;

  // Each stage loads when empty or when its contents leave this cycle
  assign out_ready = !out_valid || m_tready;
  assign in_ready  = !in_valid || out_ready;
  assign s_tready  = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && s_tvalid) begin
      in_reg <= a64sed_pkg::item_t'(s_tdata);
    end
  end

  a64sed_decode u_decode (
    .item (in_reg),
    .res  (dec_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && in_valid) begin
      out_reg <= dec_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_reg.handled;
  assign m_tdata  = {4'd0, out_reg[a64sed_pkg::OUT_W-4:1]};

  // Undecoded words produce no bytes and no writeback
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_reg.handled) |->
      (out_reg.store_bytes == 6'd0 && !out_reg.writeback_enable))
    else $error("unhandled result carries store data or writeback");

  // A handled store always writes between 1 and 32 bytes
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_reg.handled) |->
      (out_reg.store_bytes != 6'd0 && out_reg.store_bytes <= 6'd32))
    else $error("store length out of range");

  // Without writeback the register and value fields are cleared
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_reg.writeback_enable) |->
      (out_reg.writeback_reg == 5'd0 && out_reg.writeback_value == 64'd0))
    else $error("writeback fields set without writeback");

  // Both stages full and the master stalled: no room, so no input taken
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && out_valid && !m_tready) |-> !s_tready)
    else $error("input accepted with pipeline full");

  // A stalled result must not be overwritten
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_tready) |=> (out_valid && $stable(out_reg)))
    else $error("stalled result changed");

endmodule
